// ===== rtl/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types, constants and value conversions for the min-tracking stack.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_WIDTH  = 32;

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W = 2 * DATA_WIDTH;

  localparam int IO_W  = 32;  // width of value fields on the ports
  localparam int OCC_W = 7;   // width of the occupancy field

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic signed [IO_W-1:0] top_value;
    logic signed [IO_W-1:0] min_value;
    logic signed [IO_W-1:0] popped_value;
    logic [OCC_W-1:0]       occupancy;
    logic                   is_empty;
    logic [1:0]             error_code;
  } result_t;

  // Port value (32 bits) to stored value (DATA_WIDTH bits, two's complement)
  function automatic logic signed [DATA_WIDTH-1:0] to_data(logic signed [IO_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // Stored value to port value, sign-extended or truncated to 32 bits
  function automatic logic signed [IO_W-1:0] to_io(logic signed [DATA_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[IO_W-1:0];
  endfunction

endpackage

// ===== rtl/mst_ram.sv =====
// ----------------------------------------------------------------------------
// mst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mst_result.sv =====
// ----------------------------------------------------------------------------
// mst_result
// Output register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mst_result (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  mst_pkg::result_t data_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output mst_pkg::result_t data_o
);

  logic            valid_q, valid_d;
  mst_pkg::result_t data_q;

  // Room for a new beat when empty or when the held beat leaves this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/min_tracking_stack_unit.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_unit
// Bounded signed stack with running minimum; top entry in registers, the rest
// in a RAM of {value, minimum} pairs.
// ----------------------------------------------------------------------------
// Results: push, peek and pops that empty the stack or fail load the result
//   register when the input beat is accepted; a pop that leaves entries first
//   reads the RAM to refill the top registers, then loads the result register.
// Throughput: one beat per cycle while the result register has room; no new beat is taken while such a pop refills.
// Reset: occupancy clears to zero; the RAM is not cleared and is read only
//   at entries that were written.
module min_tracking_stack_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] top_value_o,
  output logic signed [31:0] min_value_o,
  output logic signed [31:0] popped_value_o,
  output logic [6:0]         occupancy_o,
  output logic               is_empty_o,
  output logic [1:0]         error_code_o
);

  localparam int DW = mst_pkg::DATA_WIDTH;
  localparam int AW = mst_pkg::ADDR_W;
  localparam int CW = mst_pkg::CNT_W;

  mst_pkg::state_e state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic signed [DW-1:0]   top_val_q, top_val_d;
  logic signed [DW-1:0]   top_min_q, top_min_d;
  logic signed [DW-1:0]   popped_q, popped_d;

  logic                   accept;
  logic                   res_free;
  logic                   res_load;
  mst_pkg::result_t       res_d;
  mst_pkg::result_t       res_q;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [2*DW-1:0]        ram_rdata;
  logic signed [DW-1:0]   push_v;
  logic signed [DW-1:0]   rd_val, rd_min;
  logic [CW-1:0]          cnt_m1, cnt_m2;

  assign in_ready_o = (state_q == mst_pkg::ST_IDLE) && res_free;
  assign accept     = in_valid_i && in_ready_o;

  assign push_v = mst_pkg::to_data(push_value_i);
  assign rd_val = ram_rdata[2*DW-1:DW];
  assign rd_min = ram_rdata[DW-1:0];
  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);

  // Old top is spilled to RAM on push; the entry below the top is fetched on pop
  assign ram_waddr = cnt_m1[AW-1:0];
  assign ram_raddr = cnt_m2[AW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    top_val_d = top_val_q;
    top_min_d = top_min_q;
    popped_d  = popped_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res_load  = 1'b0;
    res_d.error_code = mst_pkg::ERR_OK;

    case (state_q)
      mst_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            mst_pkg::CMD_PUSH: begin
              res_load = 1'b1;
              if (count_q >= CW'(mst_pkg::STACK_DEPTH)) begin
                res_d.error_code = mst_pkg::ERR_FULL;
              end else begin
                ram_we    = (count_q != '0);
                top_val_d = push_v;
                // equal values keep the existing minimum
                top_min_d = ((count_q != '0) && !(push_v < top_min_q)) ? top_min_q : push_v;
                count_d   = count_q + CW'(1);
              end
            end
            mst_pkg::CMD_POP: begin
              if (count_q == '0) begin
                res_load         = 1'b1;
                res_d.error_code = mst_pkg::ERR_EMPTY;
              end else begin
                popped_d = top_val_q;
                count_d  = cnt_m1;
                if (count_q == CW'(1)) begin
                  res_load = 1'b1;
                end else begin
                  ram_re  = 1'b1;
                  state_d = mst_pkg::ST_POP;
                end
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      mst_pkg::ST_POP: begin
        top_val_d = rd_val;
        top_min_d = rd_min;
        res_load  = 1'b1;
        state_d   = mst_pkg::ST_IDLE;
      end
      default: begin
        state_d = mst_pkg::ST_IDLE;
      end
    endcase

    // Result is built from the post-operation state
    res_d.occupancy    = mst_pkg::OCC_W'(count_d);
    res_d.is_empty     = (count_d == '0);
    res_d.top_value    = (count_d == '0) ? '0 : mst_pkg::to_io(top_val_d);
    res_d.min_value    = (count_d == '0) ? '0 : mst_pkg::to_io(top_min_d);
    res_d.popped_value = '0;
    if ((state_q == mst_pkg::ST_POP) ||
        (accept && (cmd_i == mst_pkg::CMD_POP) && (count_q != '0))) begin
      res_d.popped_value = mst_pkg::to_io(popped_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mst_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q <= top_val_d;
    top_min_q <= top_min_d;
    popped_q  <= popped_d;
  end

  mst_ram #(
    .WIDTH (mst_pkg::ENTRY_W),
    .DEPTH (mst_pkg::STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({top_val_q, top_min_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mst_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .data_i  (res_d),
    .free_o  (res_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_q)
  );

  assign top_value_o    = res_q.top_value;
  assign min_value_o    = res_q.min_value;
  assign popped_value_o = res_q.popped_value;
  assign occupancy_o    = res_q.occupancy;
  assign is_empty_o     = res_q.is_empty;
  assign error_code_o   = res_q.error_code;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(mst_pkg::STACK_DEPTH))
    else $error("entry count above stack depth");

  a_pop_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mst_pkg::ST_POP) |=> (state_q == mst_pkg::ST_IDLE) && out_valid_o)
    else $error("pop refill did not produce a result");

  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mst_pkg::ST_POP) |-> !out_valid_o)
    else $error("result register busy during pop refill");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == mst_pkg::CMD_PUSH) &&
     (count_q < CW'(mst_pkg::STACK_DEPTH))) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the stack");
`endif

endmodule
